// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared widths, status codes, handshake structs and the saturation helper
// for the tridiagonal solver.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int Q_W          = 32;
  localparam int Q_FRAC       = 16;
  localparam int PROD_W       = 48;
  localparam int SAT_IN_W     = 49;
  localparam int DIV_NUM_W    = Q_W + Q_FRAC;
  localparam int DIV_BITS     = 2;
  localparam int MAX_ROWS_DEF = 64;
  localparam int STATUS_W     = 2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ROWS = 2'd2;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic           ovf;
    logic [Q_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic           done;
    logic           ovf;
    logic [Q_W-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_res_t;

  // Clamp a wide signed value to the Q16.16 range and flag the clamp.
  function automatic sat_t sat49(input logic signed [SAT_IN_W-1:0] v);
    sat_t s;
    s.ovf = (v[SAT_IN_W-1:Q_W-1] != {(SAT_IN_W-Q_W+1){v[SAT_IN_W-1]}});
    if (s.ovf) begin
      s.val = v[SAT_IN_W-1] ? Q_MIN : Q_MAX;
    end else begin
      s.val = v[Q_W-1:0];
    end
    return s;
  endfunction

endpackage

// File: rtl/tts_mul.sv
// ----------------------------------------------------------------------------
// tts_mul
// Shared Q16.16 multiplier: operand latch, 32x32 product, then truncation of
// the product toward zero by 2^16.
// ----------------------------------------------------------------------------
module tts_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [tts_pkg::Q_W-1:0] x,
  input  logic signed [tts_pkg::Q_W-1:0] y,
  output tts_pkg::mul_res_t              res
);

  localparam int P_W = 2 * tts_pkg::Q_W;

  logic signed [tts_pkg::Q_W-1:0]    x_r, y_r;
  logic signed [P_W-1:0]             p_r;
  logic [tts_pkg::PROD_W-1:0]        t_r;
  logic [2:0]                        vld_r;
  logic [P_W-1:0]                    p_sh;
  logic                              p_frac;

  assign p_sh   = p_r >>> tts_pkg::Q_FRAC;
  // negative product with fraction bits: step back toward zero
  assign p_frac = p_r[P_W-1] && (p_r[tts_pkg::Q_FRAC-1:0] != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
    end
    p_r <= x_r * y_r;
    t_r <= p_sh[tts_pkg::PROD_W-1:0] + tts_pkg::PROD_W'(p_frac);
  end

  assign res.done = vld_r[2];
  assign res.prod = t_r;

endmodule

// File: rtl/tts_div.sv
// ----------------------------------------------------------------------------
// tts_div
// Shared iterative Q16.16 divider: (num * 2^16) / den, truncated toward zero,
// magnitude restoring division, DIV_BITS quotient bits per iteration, saturated.
// ----------------------------------------------------------------------------
module tts_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [tts_pkg::Q_W-1:0] num,
  input  logic signed [tts_pkg::Q_W-1:0] den,
  output tts_pkg::div_res_t              res
);

  localparam int NW    = tts_pkg::DIV_NUM_W;
  localparam int QW    = tts_pkg::Q_W;
  localparam int ITERS = NW / tts_pkg::DIV_BITS;
  localparam int CW    = $clog2(ITERS);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]    st_r;
  logic [CW-1:0] cnt_r;
  logic [QW-1:0] rem_r, dmag_r;
  logic [NW-1:0] dq_r;
  logic          neg_r;
  logic          done_r, ovf_r;
  logic [QW-1:0] quot_r;

  logic [QW-1:0]                    nmag, dmag;
  logic [QW-1:0]                    rem_step;
  logic [NW-1:0]                    dq_step;
  logic signed [tts_pkg::SAT_IN_W-1:0] qs;
  tts_pkg::sat_t                    qsat;

  assign nmag = num[QW-1] ? (~num + 1'b1) : num;
  assign dmag = den[QW-1] ? (~den + 1'b1) : den;

  always_comb begin
    logic [QW:0]   rem_v;
    logic [NW-1:0] dq_v;
    rem_v = {1'b0, rem_r};
    dq_v  = dq_r;
    for (int i = 0; i < tts_pkg::DIV_BITS; i++) begin
      rem_v = {rem_v[QW-1:0], dq_v[NW-1]};
      dq_v  = {dq_v[NW-2:0], 1'b0};
      if (rem_v >= {1'b0, dmag_r}) begin
        rem_v   = rem_v - {1'b0, dmag_r};
        dq_v[0] = 1'b1;
      end
    end
    rem_step = rem_v[QW-1:0];
    dq_step  = dq_v;
  end

  assign qs   = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
  assign qsat = tts_pkg::sat49(qs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        D_IDLE: begin
          if (start) begin
            if (den == '0) begin
              // zero pivot: sign of the numerator picks the rail; a zero numerator gives zero
              done_r <= 1'b1;
              ovf_r  <= 1'b1;
              if (num == '0) begin
                quot_r <= '0;
              end else begin
                quot_r <= num[QW-1] ? tts_pkg::Q_MIN : tts_pkg::Q_MAX;
              end
            end else begin
              st_r   <= D_RUN;
              cnt_r  <= CW'(ITERS - 1);
              rem_r  <= '0;
              dq_r   <= {nmag, {tts_pkg::Q_FRAC{1'b0}}};
              dmag_r <= dmag;
              neg_r  <= num[QW-1] ^ den[QW-1];
            end
          end
        end
        D_RUN: begin
          rem_r <= rem_step;
          dq_r  <= dq_step;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            st_r <= D_FIN;
          end
        end
        D_FIN: begin
          st_r   <= D_IDLE;
          done_r <= 1'b1;
          ovf_r  <= qsat.ovf;
          quot_r <= qsat.val;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = quot_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == D_IDLE)
    else $error("divider started while busy");

  a_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == D_FIN |=> done_r && st_r == D_IDLE)
    else $error("divider result not delivered after last step");

  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r || $past(start))
    else $error("divider done held without a new start");

endmodule

// File: rtl/tridiagonal_thomas_solver.sv
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver
// Thomas-algorithm solver for one tridiagonal system in signed Q16.16, using
// one shared multiplier and one shared iterative divider under a sequencer.
//
//   channel | direction | tdata (low bit up)                  | tlast    | tuser
//   in_     | slave     | sub_diag, main_diag, super_diag, rhs | last     | -
//   out_    | master    | solution                             | last_out | status
//
// The first row takes one divider pass, later rows two divider passes plus
//   two multiplies; back substitution an init step, then a read, an issue
//   and a multiply per row; each result a read, then valid until taken.
// Not ready while a row is in work, during back substitution or output.
// Reset: synchronous, active low; both row memories need no clearing pass.
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver #(
  parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // sub_diag, main_diag, super_diag, rhs
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // solution
  output logic         out_tlast,
  output logic [1:0]   out_tuser   // status
);

  localparam int QW     = tts_pkg::Q_W;
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int ADDR_W = $clog2(MAX_ROWS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADJ_MUL = 4'd1;
  localparam logic [3:0] S_R_DIV   = 4'd2;
  localparam logic [3:0] S_PIV_MUL = 4'd3;
  localparam logic [3:0] S_SOL_DIV = 4'd4;
  localparam logic [3:0] S_BK_INIT = 4'd5;
  localparam logic [3:0] S_BK_RD   = 4'd6;
  localparam logic [3:0] S_BK_ISS  = 4'd7;
  localparam logic [3:0] S_BK_MUL  = 4'd8;
  localparam logic [3:0] S_OUT_RD  = 4'd9;
  localparam logic [3:0] S_OUT_VLD = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [1:0] err_r, err_nxt;
  logic signed [QW-1:0] pivot_r, pivot_nxt;
  logic signed [QW-1:0] prev_super_r, prev_super_nxt;
  logic signed [QW-1:0] prev_sol_r, prev_sol_nxt;
  logic signed [QW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic last_r, last_nxt;
  logic signed [QW-1:0] adj_r, adj_nxt;
  logic signed [QW-1:0] x_r, x_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0] o_idx_r, o_idx_nxt;
  logic [tts_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic tlast_r, tlast_nxt;

  logic [QW-1:0] rat_mem [MAX_ROWS];
  logic [QW-1:0] sol_mem [MAX_ROWS];
  logic [QW-1:0] rat_q_r, sol_q_r;
  logic rat_we, sol_we, rat_re, sol_re;
  logic [ADDR_W-1:0] rat_waddr, sol_waddr, rat_raddr, sol_raddr;
  logic [QW-1:0] rat_wdata, sol_wdata;

  logic mul_start, div_start;
  logic signed [QW-1:0] mul_x, mul_y, div_num, div_den;
  tts_pkg::mul_res_t mul_res;
  tts_pkg::div_res_t div_res;

  logic signed [QW-1:0] in_a, in_b, in_c, in_d;
  tts_pkg::sat_t adj_sat, piv_sat, bk_sat;
  logic in_xfer, out_xfer, rows_full;

  assign in_a = in_tdata[31:0];
  assign in_b = in_tdata[63:32];
  assign in_c = in_tdata[95:64];
  assign in_d = in_tdata[127:96];

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT_VLD);
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tdata  = sol_q_r;
  assign out_tlast  = tlast_r;
  assign out_tuser  = status_r;
  assign rows_full  = (row_cnt_r >= CNT_W'(MAX_ROWS));

  assign adj_sat = tts_pkg::sat49(tts_pkg::SAT_IN_W'(d_r)
                                  - tts_pkg::SAT_IN_W'($signed(mul_res.prod)));
  assign piv_sat = tts_pkg::sat49(tts_pkg::SAT_IN_W'(b_r)
                                  - tts_pkg::SAT_IN_W'($signed(mul_res.prod)));
  assign bk_sat  = tts_pkg::sat49(tts_pkg::SAT_IN_W'($signed(sol_q_r))
                                  - tts_pkg::SAT_IN_W'($signed(mul_res.prod)));

  tts_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .res   (mul_res)
  );

  tts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  always_comb begin
    state_nxt      = state_r;
    row_cnt_nxt    = row_cnt_r;
    err_nxt        = err_r;
    pivot_nxt      = pivot_r;
    prev_super_nxt = prev_super_r;
    prev_sol_nxt   = prev_sol_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    last_nxt       = last_r;
    adj_nxt        = adj_r;
    x_nxt          = x_r;
    k_nxt          = k_r;
    o_idx_nxt      = o_idx_r;
    status_nxt     = status_r;
    tlast_nxt      = tlast_r;
    mul_start      = 1'b0;
    mul_x          = a_r;
    mul_y          = prev_sol_r;
    div_start      = 1'b0;
    div_num        = adj_r;
    div_den        = pivot_r;
    rat_we         = 1'b0;
    rat_waddr      = row_cnt_r[ADDR_W-1:0];
    rat_wdata      = div_res.quot;
    rat_re         = 1'b0;
    rat_raddr      = k_r;
    sol_we         = 1'b0;
    sol_waddr      = row_cnt_r[ADDR_W-1:0];
    sol_wdata      = div_res.quot;
    sol_re         = 1'b0;
    sol_raddr      = o_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          a_nxt    = in_a;
          b_nxt    = in_b;
          c_nxt    = in_c;
          d_nxt    = in_d;
          last_nxt = in_tlast;
          if (rows_full) begin
            // drop the row; a last flag still starts the solve
            err_nxt[1] = 1'b1;
            if (in_tlast) begin
              state_nxt = S_BK_INIT;
            end
          end else if (row_cnt_r == '0) begin
            pivot_nxt = in_b;
            div_start = 1'b1;
            div_num   = in_d;
            div_den   = in_b;
            state_nxt = S_SOL_DIV;
          end else begin
            mul_start = 1'b1;
            mul_x     = in_a;
            mul_y     = prev_sol_r;
            state_nxt = S_ADJ_MUL;
          end
        end
      end
      S_ADJ_MUL: begin
        if (mul_res.done) begin
          adj_nxt    = adj_sat.val;
          err_nxt[0] = err_r[0] | adj_sat.ovf;
          div_start  = 1'b1;
          div_num    = prev_super_r;
          div_den    = pivot_r;
          state_nxt  = S_R_DIV;
        end
      end
      S_R_DIV: begin
        if (div_res.done) begin
          rat_we     = 1'b1;
          err_nxt[0] = err_r[0] | div_res.ovf;
          mul_start  = 1'b1;
          mul_x      = a_r;
          mul_y      = div_res.quot;
          state_nxt  = S_PIV_MUL;
        end
      end
      S_PIV_MUL: begin
        if (mul_res.done) begin
          pivot_nxt  = piv_sat.val;
          err_nxt[0] = err_r[0] | piv_sat.ovf;
          div_start  = 1'b1;
          div_num    = adj_r;
          div_den    = piv_sat.val;
          state_nxt  = S_SOL_DIV;
        end
      end
      S_SOL_DIV: begin
        if (div_res.done) begin
          sol_we         = 1'b1;
          err_nxt[0]     = err_r[0] | div_res.ovf;
          prev_sol_nxt   = div_res.quot;
          prev_super_nxt = c_r;
          row_cnt_nxt    = row_cnt_r + 1'b1;
          state_nxt      = last_r ? S_BK_INIT : S_IDLE;
        end
      end
      S_BK_INIT: begin
        // the newest partial solution is already the last unknown
        x_nxt     = prev_sol_r;
        k_nxt     = ADDR_W'(row_cnt_r - 1'b1);
        o_idx_nxt = '0;
        state_nxt = (row_cnt_r == CNT_W'(1)) ? S_OUT_RD : S_BK_RD;
      end
      S_BK_RD: begin
        rat_re    = 1'b1;
        rat_raddr = k_r;
        sol_re    = 1'b1;
        sol_raddr = k_r - 1'b1;
        state_nxt = S_BK_ISS;
      end
      S_BK_ISS: begin
        mul_start = 1'b1;
        mul_x     = rat_q_r;
        mul_y     = x_r;
        state_nxt = S_BK_MUL;
      end
      S_BK_MUL: begin
        if (mul_res.done) begin
          sol_we     = 1'b1;
          sol_waddr  = k_r - 1'b1;
          sol_wdata  = bk_sat.val;
          err_nxt[0] = err_r[0] | bk_sat.ovf;
          x_nxt      = bk_sat.val;
          k_nxt      = k_r - 1'b1;
          state_nxt  = (k_r == ADDR_W'(1)) ? S_OUT_RD : S_BK_RD;
        end
      end
      S_OUT_RD: begin
        sol_re    = 1'b1;
        sol_raddr = o_idx_r;
        tlast_nxt = (CNT_W'(o_idx_r) + CNT_W'(1)) == row_cnt_r;
        if (err_r[1]) begin
          status_nxt = tts_pkg::ST_ROWS;
        end else if (err_r[0]) begin
          status_nxt = tts_pkg::ST_SAT;
        end else begin
          status_nxt = tts_pkg::ST_OK;
        end
        state_nxt = S_OUT_VLD;
      end
      S_OUT_VLD: begin
        if (out_xfer) begin
          if (tlast_r) begin
            // system done: clear for the next one
            pivot_nxt      = '0;
            prev_super_nxt = '0;
            row_cnt_nxt    = '0;
            err_nxt        = '0;
            state_nxt      = S_IDLE;
          end else begin
            o_idx_nxt = o_idx_r + 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_cnt_r    <= '0;
      err_r        <= '0;
      pivot_r      <= '0;
      prev_super_r <= '0;
    end else begin
      state_r      <= state_nxt;
      row_cnt_r    <= row_cnt_nxt;
      err_r        <= err_nxt;
      pivot_r      <= pivot_nxt;
      prev_super_r <= prev_super_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_sol_r <= prev_sol_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    last_r     <= last_nxt;
    adj_r      <= adj_nxt;
    x_r        <= x_nxt;
    k_r        <= k_nxt;
    o_idx_r    <= o_idx_nxt;
    status_r   <= status_nxt;
    tlast_r    <= tlast_nxt;
  end

  always_ff @(posedge clk) begin
    if (rat_we) begin
      rat_mem[rat_waddr] <= rat_wdata;
    end
    if (rat_re) begin
      rat_q_r <= rat_mem[rat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sol_we) begin
      sol_mem[sol_waddr] <= sol_wdata;
    end
    if (sol_re) begin
      sol_q_r <= sol_mem[sol_raddr];
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open at once");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r <= CNT_W'(MAX_ROWS))
    else $error("row count beyond capacity");

  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_tlast |=> row_cnt_r == '0 && err_r == '0 && in_tready)
    else $error("system state not cleared after final result");

  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_res.done |-> state_r == S_ADJ_MUL || state_r == S_PIV_MUL
                     || state_r == S_BK_MUL)
    else $error("product arrived outside a multiply wait");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_R_DIV || state_r == S_SOL_DIV)
    else $error("quotient arrived outside a divide wait");

endmodule
